FILE: hdl/red_drop_decider_top_macros.svh
// assertion helpers, sampled on i_clk and off while in reset
`ifndef RED_DROP_DECIDER_TOP_MACROS_SVH
`define RED_DROP_DECIDER_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define RDD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RDD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rdd_pkg.sv
package rdd_pkg;

    localparam int QUEUE_LEN_BITS_DEF = 16;
    localparam int PROB_FRAC_BITS_DEF = 16;

    localparam int TAG_W     = 16;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [TAG_W-1:0]     t_tag;
    typedef logic [CNT_W-1:0]     t_drop_cnt;

    localparam t_cfg_idx CFG_MIN_THRESHOLD = 2'd0;
    localparam t_cfg_idx CFG_MAX_THRESHOLD = 2'd1;
    localparam t_cfg_idx CFG_PROB_AT_MIN   = 2'd2;
    localparam t_cfg_idx CFG_PROB_AT_MAX   = 2'd3;

endpackage

FILE: hdl/rdd_cfg.sv
module rdd_cfg
    import rdd_pkg::*;
#(
    parameter int QUEUE_LEN_BITS = QUEUE_LEN_BITS_DEF,
    parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  t_cfg_idx                              i_cfg_idx,
    input  logic [((QUEUE_LEN_BITS > PROB_FRAC_BITS + 1) ?
                   QUEUE_LEN_BITS : PROB_FRAC_BITS + 1)-1:0] i_cfg_data,
    output logic [QUEUE_LEN_BITS-1:0]             o_min_threshold,
    output logic [QUEUE_LEN_BITS-1:0]             o_max_threshold,
    output logic [PROB_FRAC_BITS:0]               o_prob_at_min,
    output logic [PROB_FRAC_BITS:0]               o_prob_at_max
);

    localparam logic [PROB_FRAC_BITS:0] P_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};

    logic [QUEUE_LEN_BITS-1:0] r_min_thr, n_min_thr;
    logic [QUEUE_LEN_BITS-1:0] r_max_thr, n_max_thr;
    logic [PROB_FRAC_BITS:0]   r_pam, n_pam;
    logic [PROB_FRAC_BITS:0]   r_pax, n_pax;
    logic [PROB_FRAC_BITS:0]   prob_in;
    logic [PROB_FRAC_BITS:0]   prob_sat;

    // probabilities above one clamp to one
    assign prob_in  = i_cfg_data[PROB_FRAC_BITS:0];
    assign prob_sat = (prob_in > P_ONE) ? P_ONE : prob_in;

    always_comb begin
        n_min_thr = r_min_thr;
        n_max_thr = r_max_thr;
        n_pam     = r_pam;
        n_pax     = r_pax;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_THRESHOLD: n_min_thr = i_cfg_data[QUEUE_LEN_BITS-1:0];
                CFG_MAX_THRESHOLD: n_max_thr = i_cfg_data[QUEUE_LEN_BITS-1:0];
                CFG_PROB_AT_MIN:   n_pam     = prob_sat;
                CFG_PROB_AT_MAX:   n_pax     = prob_sat;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_thr <= '0;
            r_max_thr <= '1;
            r_pam     <= '0;
            r_pax     <= P_ONE;
        end else begin
            r_min_thr <= n_min_thr;
            r_max_thr <= n_max_thr;
            r_pam     <= n_pam;
            r_pax     <= n_pax;
        end
    end

    assign o_min_threshold = r_min_thr;
    assign o_max_threshold = r_max_thr;
    assign o_prob_at_min   = r_pam;
    assign o_prob_at_max   = r_pax;

endmodule

FILE: hdl/rdd_interp.sv
`include "red_drop_decider_top_macros.svh"

module rdd_interp
    import rdd_pkg::*;
#(
    parameter int QUEUE_LEN_BITS = QUEUE_LEN_BITS_DEF,
    parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [PROB_FRAC_BITS:0]   i_base,
    input  logic [PROB_FRAC_BITS:0]   i_mag,
    input  logic                      i_neg,
    input  logic [QUEUE_LEN_BITS-1:0] i_off,
    input  logic [QUEUE_LEN_BITS-1:0] i_span,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [PROB_FRAC_BITS:0]   o_result
);

    // one quotient digit per cycle, multiplier bits taken msb first
    localparam int CW = $clog2(PROB_FRAC_BITS + 1);
    localparam int XW = QUEUE_LEN_BITS + 2;

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [PROB_FRAC_BITS:0]   r_mag, n_mag;
    logic [PROB_FRAC_BITS:0]   r_base, n_base;
    logic                      r_neg, n_neg;
    logic [QUEUE_LEN_BITS-1:0] r_off, n_off;
    logic [QUEUE_LEN_BITS-1:0] r_span, n_span;
    logic [QUEUE_LEN_BITS-1:0] r_rem, n_rem;
    logic [PROB_FRAC_BITS:0]   r_quo, n_quo;

    logic [XW-1:0]             x;
    logic [XW-1:0]             span1;
    logic [XW-1:0]             span2;
    logic [XW-1:0]             x_left;
    logic [1:0]                digit;
    logic [PROB_FRAC_BITS+1:0] sum;

    assign span1 = {2'b00, r_span};
    assign span2 = {1'b0, r_span, 1'b0};
    assign x     = {1'b0, r_rem, 1'b0} + (r_mag[r_cnt] ? {2'b00, r_off} : '0);

    // x stays below three times the span, so the digit is 0, 1 or 2
    always_comb begin
        if (x >= span2) begin
            digit  = 2'd2;
            x_left = x - span2;
        end else if (x >= span1) begin
            digit  = 2'd1;
            x_left = x - span1;
        end else begin
            digit  = 2'd0;
            x_left = x;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_mag  = r_mag;
        n_base = r_base;
        n_neg  = r_neg;
        n_off  = r_off;
        n_span = r_span;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = CW'(PROB_FRAC_BITS);
            n_mag  = i_mag;
            n_base = i_base;
            n_neg  = i_neg;
            n_off  = i_off;
            n_span = i_span;
            n_rem  = '0;
            n_quo  = '0;
        end else if (r_busy) begin
            n_rem = x_left[QUEUE_LEN_BITS-1:0];
            n_quo = {r_quo[PROB_FRAC_BITS-1:0], 1'b0} +
                    {{(PROB_FRAC_BITS-1){1'b0}}, digit};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_mag  <= n_mag;
        r_base <= n_base;
        r_neg  <= n_neg;
        r_off  <= n_off;
        r_span <= n_span;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
    end

    // sign and magnitude, so a falling slope truncates toward zero
    assign sum = r_neg ? ({1'b0, r_base} - {1'b0, r_quo})
                       : ({1'b0, r_base} + {1'b0, r_quo});

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = sum[PROB_FRAC_BITS:0];

    `RDD_ASSERT_IMPL(a_rem_below_span, r_busy, r_rem < r_span, "remainder not below span")
    `RDD_ASSERT_IMPL(a_quo_bounded, r_done, r_quo <= r_mag, "quotient above slope magnitude")
    `RDD_ASSERT_IMPL(a_start_idle, i_start, !r_busy, "start while busy")

endmodule

FILE: hdl/red_drop_decider_top.sv
// random early detection drop decider
// input channel (i_valid / o_ready) carries two kinds of item, picked by i_func:
//   queue report (i_func = 1): updates the stored drop probability, no result
//   packet (i_func = 0): compares i_coin with the probability, one result
// output channel (o_valid / i_ready) carries verdict, tag and drop count
// configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data, no wait;
//   0 min threshold, 1 max threshold, 2 prob at min, 3 prob at max
// packet: result is shown the cycle after its transfer, one packet per cycle
//   while the receiver keeps up and no queue report is being interpolated
// queue report between the thresholds: the stored probability is computed by
//   the divide unit, producing one quotient digit a cycle, and no item is taken
//   meanwhile; other reports update it in the cycle after their transfer
// receiver stall: one result is held in the output register; further packets
//   wait, queue reports still go through
// reset: thresholds 0 and all ones, probabilities 0 and one, stored
//   probability and drop count zero, no result pending
`include "red_drop_decider_top_macros.svh"

module red_drop_decider_top
    import rdd_pkg::*;
#(
    parameter int QUEUE_LEN_BITS = QUEUE_LEN_BITS_DEF,
    parameter int PROB_FRAC_BITS = PROB_FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_func,
    input  logic [QUEUE_LEN_BITS-1:0] i_queue_length,
    input  logic [PROB_FRAC_BITS-1:0] i_coin,
    input  t_tag                      i_packet_tag,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_verdict,
    output t_tag                      o_out_tag,
    output t_drop_cnt                 o_total_drops,
    input  logic                      i_cfg_we,
    input  t_cfg_idx                  i_cfg_idx,
    input  logic [((QUEUE_LEN_BITS > PROB_FRAC_BITS + 1) ?
                   QUEUE_LEN_BITS : PROB_FRAC_BITS + 1)-1:0] i_cfg_data
);

    localparam logic [PROB_FRAC_BITS:0] P_ONE = {1'b1, {PROB_FRAC_BITS{1'b0}}};
    localparam logic S_IDLE = 1'b0;
    localparam logic S_CALC = 1'b1;

    logic [QUEUE_LEN_BITS-1:0] min_thr;
    logic [QUEUE_LEN_BITS-1:0] max_thr;
    logic [PROB_FRAC_BITS:0]   pam;
    logic [PROB_FRAC_BITS:0]   pax;

    logic                      r_state, n_state;
    logic [PROB_FRAC_BITS:0]   r_prob, n_prob;
    t_drop_cnt                 r_drops, n_drops;
    logic                      r_o_valid, n_o_valid;
    logic                      r_verdict, n_verdict;
    t_tag                      r_tag, n_tag;

    logic                      out_free;
    logic                      in_xfer;
    logic                      drop;
    logic                      interp;
    logic [PROB_FRAC_BITS:0]   p_direct;
    logic                      slope_neg;
    logic [PROB_FRAC_BITS:0]   slope_mag;
    logic [QUEUE_LEN_BITS-1:0] off;
    logic [QUEUE_LEN_BITS-1:0] span;
    logic                      start;
    logic                      calc_busy;
    logic                      calc_done;
    logic [PROB_FRAC_BITS:0]   calc_result;

    rdd_cfg #(
        .QUEUE_LEN_BITS(QUEUE_LEN_BITS),
        .PROB_FRAC_BITS(PROB_FRAC_BITS)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_min_threshold(min_thr),
        .o_max_threshold(max_thr),
        .o_prob_at_min  (pam),
        .o_prob_at_max  (pax)
    );

    rdd_interp #(
        .QUEUE_LEN_BITS(QUEUE_LEN_BITS),
        .PROB_FRAC_BITS(PROB_FRAC_BITS)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_base  (pam),
        .i_mag   (slope_mag),
        .i_neg   (slope_neg),
        .i_off   (off),
        .i_span  (span),
        .o_busy  (calc_busy),
        .o_done  (calc_done),
        .o_result(calc_result)
    );

    assign out_free = !r_o_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && (i_func || out_free);
    assign in_xfer  = i_valid && o_ready;

    // threshold tests, the later test wins
    always_comb begin
        p_direct = r_prob;
        if (i_queue_length < min_thr) begin
            p_direct = '0;
        end
        if (i_queue_length == min_thr) begin
            p_direct = pam;
        end
        if (i_queue_length == max_thr) begin
            p_direct = pax;
        end
        if (i_queue_length > max_thr) begin
            p_direct = P_ONE;
        end
    end

    assign interp    = (i_queue_length > min_thr) && (i_queue_length < max_thr);
    assign slope_neg = pax < pam;
    assign slope_mag = slope_neg ? (pam - pax) : (pax - pam);
    assign off       = i_queue_length - min_thr;
    assign span      = max_thr - min_thr;
    assign start     = in_xfer && i_func && interp;

    assign drop = {1'b0, i_coin} <= r_prob;

    always_comb begin
        n_state   = r_state;
        n_prob    = r_prob;
        n_drops   = r_drops;
        n_o_valid = r_o_valid && !i_ready;
        n_verdict = r_verdict;
        n_tag     = r_tag;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_func) begin
                        if (interp) begin
                            n_state = S_CALC;
                        end else begin
                            n_prob = p_direct;
                        end
                    end else begin
                        if (drop && (r_drops != '1)) begin
                            n_drops = r_drops + 1'b1;
                        end
                        n_o_valid = 1'b1;
                        n_verdict = drop;
                        n_tag     = i_packet_tag;
                    end
                end
            end
            S_CALC: begin
                if (calc_done) begin
                    n_prob  = calc_result;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_prob    <= '0;
            r_drops   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_prob    <= n_prob;
            r_drops   <= n_drops;
            r_o_valid <= n_o_valid;
        end
        r_verdict <= n_verdict;
        r_tag     <= n_tag;
    end

    assign o_valid       = r_o_valid;
    assign o_verdict     = r_verdict;
    assign o_out_tag     = r_tag;
    assign o_total_drops = r_drops;

    `RDD_ASSERT_ALWAYS(a_prob_le_one, r_prob <= P_ONE, "stored probability above one")
    `RDD_ASSERT_IMPL(a_calc_in_progress, (r_state == S_CALC) && !calc_done, calc_busy,
        "waiting on an idle divide unit")
    `RDD_ASSERT_IMPL(a_done_only_in_calc, calc_done, r_state == S_CALC,
        "divide result with no report pending")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rdd_pkg::*;

    localparam int QW = QUEUE_LEN_BITS_DEF;
    localparam int PW = PROB_FRAC_BITS_DEF;
    localparam int CFG_W = (QW > PW + 1) ? QW : PW + 1;
    localparam logic [PW:0] PROB_ONE = (PW + 1)'(1) << PW;

    localparam logic FUNC_PACKET = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;
    localparam logic VERDICT_FORWARD = 1'b0;
    localparam logic VERDICT_DROP = 1'b1;

    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int DIR_ROWS = 43;

    typedef struct {
        logic          func;
        logic [QW-1:0] qlen;
        logic [PW-1:0] coin;
        t_tag          tag;
    } t_red_item;

    typedef struct {
        logic      verdict;
        t_tag      tag;
        t_drop_cnt drops;
    } t_verdict;

    typedef enum int {ROW_PACKET, ROW_REPORT, ROW_CFG} t_row_kind;

    // arg is the coin on packets, the queue length on reports, the data on register rows
    typedef struct {
        t_row_kind        kind;
        t_cfg_idx         idx;
        logic [CFG_W-1:0] arg;
        t_tag             tag;
        bit               typed;
        logic             exp_verdict;
        t_drop_cnt        exp_drops;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_func;
    logic [QW-1:0]       i_queue_length;
    logic [PW-1:0]       i_coin;
    t_tag                i_packet_tag;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic                o_verdict;
    t_tag                o_out_tag;
    t_drop_cnt           o_total_drops;
    logic                i_cfg_we;
    t_cfg_idx            i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;

    // predictor state, reset values
    logic [QW-1:0] cfg_qmin = '0;
    logic [QW-1:0] cfg_qmax = '1;
    logic [PW:0]   cfg_pmin = '0;
    logic [PW:0]   cfg_pmax = PROB_ONE;
    logic [PW:0]   live_prob = '0;
    t_drop_cnt     drops_so_far = '0;

    t_verdict pending_verdicts[$];
    int       err_count = 0;
    int       cycle_count = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        // straight after reset: probability zero, full span
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 0,       'h0000, 1'b1, VERDICT_DROP,    32'd1},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 1,       'hFFFF, 1'b1, VERDICT_FORWARD, 32'd1},
        '{ROW_REPORT, CFG_MIN_THRESHOLD, 65535,   'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 65535,   'h1234, 1'b1, VERDICT_DROP,    32'd2},
        '{ROW_REPORT, CFG_MIN_THRESHOLD, 0,       'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 0,       'hAAAA, 1'b1, VERDICT_DROP,    32'd3},
        '{ROW_REPORT, CFG_MIN_THRESHOLD, 32768,   'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 32768,   'h5555, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 32769,   'h00FF, 1'b0, VERDICT_FORWARD, 32'd0},
        // falling slope, prob at min saturates to one
        '{ROW_CFG,    CFG_MIN_THRESHOLD, 100,     'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_CFG,    CFG_MAX_THRESHOLD, 200,     'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_CFG,    CFG_PROB_AT_MIN,   131071,  'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_CFG,    CFG_PROB_AT_MAX,   0,       'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_REPORT, CFG_MIN_THRESHOLD, 150,     'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 32768,   'h0F0F, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_REPORT, CFG_MIN_THRESHOLD, 101,     'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 64881,   'hF0F0, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 64882,   'h0101, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_REPORT, CFG_MIN_THRESHOLD, 99,      'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 0,       'h8000, 1'b0, VERDICT_FORWARD, 32'd0},
        // min above max, upper data bit on a threshold write is dropped
        '{ROW_CFG,    CFG_MIN_THRESHOLD, 'h1012C, 'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_CFG,    CFG_MAX_THRESHOLD, 200,     'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_CFG,    CFG_PROB_AT_MIN,   1000,    'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_CFG,    CFG_PROB_AT_MAX,   2000,    'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_REPORT, CFG_MIN_THRESHOLD, 250,     'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 65535,   'h7FFF, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_REPORT, CFG_MIN_THRESHOLD, 200,     'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 2000,    'h2000, 1'b0, VERDICT_FORWARD, 32'd0},
        // min equal to max
        '{ROW_CFG,    CFG_MIN_THRESHOLD, 500,     'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_CFG,    CFG_MAX_THRESHOLD, 500,     'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_CFG,    CFG_PROB_AT_MIN,   123,     'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_CFG,    CFG_PROB_AT_MAX,   4567,    'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_REPORT, CFG_MIN_THRESHOLD, 500,     'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 4567,    'h4567, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 4568,    'h4568, 1'b0, VERDICT_FORWARD, 32'd0},
        // threshold extremes swapped, prob at max just above one
        '{ROW_CFG,    CFG_MIN_THRESHOLD, 65535,   'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_CFG,    CFG_MAX_THRESHOLD, 0,       'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_CFG,    CFG_PROB_AT_MIN,   0,       'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_CFG,    CFG_PROB_AT_MAX,   65537,   'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_REPORT, CFG_MIN_THRESHOLD, 65535,   'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 65535,   'hC3C3, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_REPORT, CFG_MIN_THRESHOLD, 0,       'h0000, 1'b0, VERDICT_FORWARD, 32'd0},
        '{ROW_PACKET, CFG_MIN_THRESHOLD, 0,       'h3C3C, 1'b0, VERDICT_FORWARD, 32'd0}
    };

    red_drop_decider_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_queue_length (i_queue_length),
        .i_coin         (i_coin),
        .i_packet_tag   (i_packet_tag),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_verdict      (o_verdict),
        .o_out_tag      (o_out_tag),
        .o_total_drops  (o_total_drops),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [PW:0] clip_to_one(input logic [PW:0] val);
        return (val > PROB_ONE) ? PROB_ONE : val;
    endfunction

    function automatic void apply_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_MIN_THRESHOLD: cfg_qmin = data[QW-1:0];
            CFG_MAX_THRESHOLD: cfg_qmax = data[QW-1:0];
            CFG_PROB_AT_MIN:   cfg_pmin = clip_to_one(data[PW:0]);
            CFG_PROB_AT_MAX:   cfg_pmax = clip_to_one(data[PW:0]);
            default: ;
        endcase
    endfunction

    // later tests override earlier ones, interpolation only strictly between
    function automatic logic [PW:0] interp_prob(input logic [QW-1:0] q);
        logic [PW:0] p;
        longint      slope;
        longint      span;
        longint      offs;
        p = live_prob;
        if (q < cfg_qmin) p = '0;
        if (q == cfg_qmin) p = cfg_pmin;
        if (q == cfg_qmax) p = cfg_pmax;
        if (q > cfg_qmax) p = PROB_ONE;
        if (q > cfg_qmin && q < cfg_qmax) begin
            slope = longint'(cfg_pmax) - longint'(cfg_pmin);
            span  = longint'(cfg_qmax) - longint'(cfg_qmin);
            offs  = longint'(q) - longint'(cfg_qmin);
            p = (PW + 1)'(longint'(cfg_pmin) + (slope * offs) / span);
        end
        return p;
    endfunction

    // returns 1 when the item yields a verdict
    function automatic bit red_decide(input t_red_item it, output t_verdict v);
        bit drop;
        v = '{verdict: VERDICT_FORWARD, tag: '0, drops: '0};
        if (it.func == FUNC_REPORT) begin
            live_prob = interp_prob(it.qlen);
            return 1'b0;
        end
        drop = ((PW + 1)'(it.coin) <= live_prob);
        if (drop && drops_so_far != '1) drops_so_far = drops_so_far + 1;
        v.verdict = drop ? VERDICT_DROP : VERDICT_FORWARD;
        v.tag     = it.tag;
        v.drops   = drops_so_far;
        return 1'b1;
    endfunction

    function automatic logic [CFG_W-1:0] pick_prob();
        case ($urandom_range(3))
            0: return '0;
            1: return CFG_W'(PROB_ONE);
            2: return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(0, int'(PROB_ONE)));
        endcase
    endfunction

    // returns at the edge where the transfer happens
    task automatic send_item(input t_red_item it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= it.func;
        i_queue_length <= it.qlen;
        i_coin         <= it.coin;
        i_packet_tag   <= it.tag;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // drop valid, wait for all verdicts, then give a report in flight time to finish
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
    endtask

    always @(posedge i_clk) begin : verdict_check
        t_verdict want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected verdict transfer, tag %h", o_out_tag);
                err_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, o_verdict);
                    err_count++;
                end
                if (o_out_tag !== want.tag) begin
                    $error("out_tag: expected %h, got %h", want.tag, o_out_tag);
                    err_count++;
                end
                if (o_total_drops !== want.drops) begin
                    $error("total_drops: expected %0d, got %0d", want.drops, o_total_drops);
                    err_count++;
                end
            end
        end
        i_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_red_item        it;
        t_verdict         v;
        bit               in_cfg;
        int               phase;
        int               n;
        int               pause_at;
        int               qa;
        int               qb;
        logic [CFG_W-1:0] pa;
        logic [CFG_W-1:0] pb;

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_func         <= FUNC_PACKET;
        i_queue_length <= '0;
        i_coin         <= '0;
        i_packet_tag   <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_MIN_THRESHOLD;
        i_cfg_data     <= '0;
        send_idle_pct = 36;
        recv_idle_pct = 48;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_cfg = 1'b0;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                if (!in_cfg) settle();
                in_cfg = 1'b1;
                write_reg(dir_rows[r].idx, dir_rows[r].arg);
            end else begin
                if (in_cfg) i_cfg_we <= 1'b0;
                in_cfg = 1'b0;
                it.func = (dir_rows[r].kind == ROW_REPORT) ? FUNC_REPORT : FUNC_PACKET;
                it.qlen = QW'(dir_rows[r].arg);
                it.coin = PW'(dir_rows[r].arg);
                it.tag  = dir_rows[r].tag;
                send_item(it);
                if (red_decide(it, v)) begin
                    if (dir_rows[r].typed) begin
                        v.verdict = dir_rows[r].exp_verdict;
                        v.drops   = dir_rows[r].exp_drops;
                    end
                    pending_verdicts.push_back(v);
                end
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == 3) begin
                send_idle_pct = 48;
                recv_idle_pct = 36;
            end
            if (phase == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();

            case (phase)
                0: begin
                    qa = 0;
                    qb = 2 ** QW - 1;
                end
                1: begin
                    qa = $urandom_range(0, 2 ** QW - 100);
                    qb = qa + $urandom_range(1, 64);
                end
                2: begin
                    qa = $urandom_range(1000, 2 ** QW - 1);
                    qb = $urandom_range(0, qa - 1);
                end
                3: begin
                    qa = $urandom_range(0, 2 ** QW - 1);
                    qb = qa;
                end
                4: begin
                    qa = 0;
                    qb = 2 ** QW - 1;
                end
                default: begin
                    qa = $urandom_range(0, 2 ** QW - 1);
                    qb = $urandom_range(0, 2 ** QW - 1);
                end
            endcase
            pa = pick_prob();
            pb = pick_prob();
            if (phase == 4) begin
                pa = '1;
                pb = '0;
            end
            // junk in the bit above a threshold must be ignored
            write_reg(CFG_MIN_THRESHOLD, CFG_W'(qa) | (CFG_W'($urandom_range(1)) << QW));
            write_reg(CFG_MAX_THRESHOLD, CFG_W'(qb) | (CFG_W'($urandom_range(1)) << QW));
            write_reg(CFG_PROB_AT_MIN, pa);
            write_reg(CFG_PROB_AT_MAX, pb);
            i_cfg_we <= 1'b0;

            pause_at = $urandom_range(10, ITEMS_PER_PHASE - 10);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == pause_at) settle();
                it.tag  = t_tag'($urandom);
                it.coin = PW'($urandom);
                it.qlen = QW'($urandom);
                it.func = FUNC_PACKET;
                if ($urandom_range(99) < 35) begin
                    it.func = FUNC_REPORT;
                    // aim at the threshold boundaries and the slope
                    case ($urandom_range(5))
                        0: it.qlen = QW'(int'(cfg_qmin) + int'($urandom_range(2)) - 1);
                        1: it.qlen = QW'(int'(cfg_qmax) + int'($urandom_range(2)) - 1);
                        2, 3: begin
                            if (cfg_qmin < cfg_qmax)
                                it.qlen = QW'($urandom_range(int'(cfg_qmax), int'(cfg_qmin)));
                        end
                        4: it.qlen = $urandom_range(1) ? '1 : '0;
                        default: ;
                    endcase
                end else if ($urandom_range(2) == 0) begin
                    if (live_prob >= PROB_ONE)
                        it.coin = '1;
                    else
                        it.coin = PW'(int'(live_prob) + int'($urandom_range(2)) - 1);
                end
                send_item(it);
                if (red_decide(it, v)) pending_verdicts.push_back(v);
            end
        end

        settle();
        if (err_count == 0 && pending_verdicts.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
